// ===== hw/rtl/alfr_pkg.sv =====
// Package with the constants, types and helpers of the lagged Fibonacci generator.
package alfr_pkg;

  // Ring geometry.
  localparam int unsigned RING_DEPTH = 55;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned WORD_W     = 32;

  // Lehmer reseed constants.
  localparam logic [WORD_W-1:0] SEED_OFFSET = 32'd91648253;
  localparam int unsigned       MULT_W      = 21;
  localparam logic [MULT_W-1:0] LEHMER_MULT = 21'd1389796;
  localparam int unsigned       MOD_W       = 31;
  localparam logic [WORD_W-1:0] LEHMER_MOD  = 32'd2147483647;
  localparam int unsigned       PROD_W      = WORD_W + MULT_W;

  // Pointer start values after reset and after a reseed.
  localparam logic [PTR_W-1:0] WRITE_START = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] LAG_START   = PTR_W'(23);

  // Item kinds carried on the input tuser.
  typedef enum logic {
    KIND_DRAW   = 1'b0,
    KIND_RESEED = 1'b1
  } kind_e;

  // Step a ring pointer down by one, wrapping from zero to the top entry.
  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
    if ((p == '0) || (p >= PTR_W'(RING_DEPTH))) begin
      return PTR_W'(RING_DEPTH - 1);
    end
    return p - 1'b1;
  endfunction

endpackage

// ===== hw/rtl/additive_lagged_fibonacci_rng_core.sv =====
// Additive lagged Fibonacci generator (lags 55 and 24) with its ring held in a block memory.
//
// A draw beat (tuser = 0) returns one 32-bit word, the sum modulo 2^32 of the two ring words
// selected after both pointers step down; the sum is written back into the ring. In a draw, the
// acceptance cycle issues both reads to the two-read-port ring memory, and the next cycle adds
// the registered read data, writes the sum back and loads the output register, so a new draw
// is not taken while one is in progress. A result that is not taken at once moves into a
// one-entry skid register; the input also stalls while that register is full. A reseed beat
// (tuser = 1) gives no result and refills all 55 entries from a Lehmer sequence, each entry by
// a 32 x 21 multiply, then a fold modulo 2^31 - 1, and the input is not ready until the refill
// is done. Before the first reseed the ring reads as all zeros.
module additive_lagged_fibonacci_rng_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [alfr_pkg::WORD_W-1:0] s_axis_tdata,  // [31:0] seed_value
  input  logic                        s_axis_tuser,  // [0] kind
  // Output stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [alfr_pkg::WORD_W-1:0] m_axis_tdata   // [31:0] random_word
);
  import alfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SEED_MUL,
    ST_SEED_FOLD
  } state_e;

  state_e             state_q;
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   lag_ptr_q;
  logic [PTR_W-1:0]   seed_idx_q;
  logic [WORD_W-1:0]  seed_q;
  logic [PROD_W-1:0]  prod_q;
  logic               out_valid_q;
  logic [WORD_W-1:0]  out_data_q;
  logic               pend_valid_q;
  logic [WORD_W-1:0]  pend_data_q;

  // Ring memory, its per-entry valid bits and the registered read side.
  logic [WORD_W-1:0]  ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_valid_q;
  logic [WORD_W-1:0]  rd_a_q;
  logic [WORD_W-1:0]  rd_b_q;
  logic               rd_a_valid_q;
  logic               rd_b_valid_q;

  logic               in_beat;
  logic               out_beat;
  logic [PTR_W-1:0]   rd_a_addr;
  logic [PTR_W-1:0]   rd_b_addr;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  draw_sum;
  logic [WORD_W-1:0]  fold_sum;
  logic [WORD_W-1:0]  fold_res;

  assign s_axis_tready = (state_q == ST_IDLE) && !pend_valid_q;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = out_valid_q && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Reads always look at the entries the pointers step to on the next draw.
  assign rd_a_addr = step_down(wr_ptr_q);
  assign rd_b_addr = step_down(lag_ptr_q);

  // Entries never written read as zero.
  assign draw_sum = (rd_a_valid_q ? rd_a_q : '0) + (rd_b_valid_q ? rd_b_q : '0);

  // Fold the product modulo 2^31 - 1: high part plus low part, then one correction.
  assign fold_sum = WORD_W'(prod_q[PROD_W-1:MOD_W]) + WORD_W'(prod_q[MOD_W-1:0]);
  assign fold_res = (fold_sum >= LEHMER_MOD) ? (fold_sum - LEHMER_MOD) : fold_sum;

  // Single write port: seeding writes the Lehmer word, a draw writes its sum.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q;
    mem_wdata = draw_sum;
    if (state_q == ST_DRAW) begin
      mem_we = 1'b1;
    end else if (state_q == ST_SEED_FOLD) begin
      mem_we    = 1'b1;
      mem_waddr = seed_idx_q;
      mem_wdata = fold_res;
    end
  end

  // Ring memory with one write and two registered reads.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= ring_mem[rd_a_addr];
    rd_b_q <= ring_mem[rd_b_addr];
  end

  // Valid bits stand in for the all-zero reset of the ring.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_valid_q <= '0;
      rd_a_valid_q <= 1'b0;
      rd_b_valid_q <= 1'b0;
    end else begin
      if (mem_we) begin
        ring_valid_q[mem_waddr] <= 1'b1;
      end
      rd_a_valid_q <= ring_valid_q[rd_a_addr];
      rd_b_valid_q <= ring_valid_q[rd_b_addr];
    end
  end

  // Sequencer, pointers, seeding datapath and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wr_ptr_q     <= WRITE_START;
      lag_ptr_q    <= LAG_START;
      seed_idx_q   <= '0;
      seed_q       <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      pend_valid_q <= 1'b0;
      pend_data_q  <= '0;
    end else begin
      // Drain the output register, refilling it from the skid entry. A draw that
      // finishes in this cycle reloads the output register itself.
      if (out_beat) begin
        if (pend_valid_q) begin
          out_data_q   <= pend_data_q;
          pend_valid_q <= 1'b0;
        end else if (state_q != ST_DRAW) begin
          out_valid_q <= 1'b0;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (kind_e'(s_axis_tuser) == KIND_RESEED) begin
              seed_q     <= s_axis_tdata + SEED_OFFSET;
              seed_idx_q <= '0;
              wr_ptr_q   <= WRITE_START;
              lag_ptr_q  <= LAG_START;
              state_q    <= ST_SEED_MUL;
            end else begin
              wr_ptr_q  <= rd_a_addr;
              lag_ptr_q <= rd_b_addr;
              state_q   <= ST_DRAW;
            end
          end
        end
        ST_DRAW: begin
          // The skid entry is empty here, since the input only opens when it is.
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= draw_sum;
          end else begin
            pend_valid_q <= 1'b1;
            pend_data_q  <= draw_sum;
          end
          state_q <= ST_IDLE;
        end
        ST_SEED_MUL: begin
          prod_q  <= seed_q * LEHMER_MULT;
          state_q <= ST_SEED_FOLD;
        end
        ST_SEED_FOLD: begin
          seed_q <= fold_res;
          if (seed_idx_q == PTR_W'(RING_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            seed_idx_q <= seed_idx_q + 1'b1;
            state_q    <= ST_SEED_MUL;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/alfr_checker.sv =====
// Port-level checker for the lagged Fibonacci generator and its bind to the top level.
module alfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [alfr_pkg::WORD_W-1:0] m_axis_tdata
);
  import alfr_pkg::*;

  logic in_beat;
  logic seeded_q;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // Remembers whether any reseed beat has been taken since reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
    end else if (in_beat && (kind_e'(s_axis_tuser) == KIND_RESEED)) begin
      seeded_q <= 1'b1;
    end
  end

  // Every accepted beat keeps the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready)
    else $error("input ready in the cycle after an accepted beat");

  // A reseed keeps the block busy during the fill; the property samples ready at one point of it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (kind_e'(s_axis_tuser) == KIND_RESEED)) |=> ##2 !s_axis_tready)
    else $error("input ready while the ring is still being refilled");

  // A stalled result holds its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output beat dropped or changed while stalled");

  // Until the first reseed the ring is all zeros, so every draw is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata != '0)) |-> seeded_q)
    else $error("nonzero word before any reseed");

endmodule

bind additive_lagged_fibonacci_rng_core alfr_checker u_alfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
